// ----- hw/rtl/eft_pkg.sv -----
// Package for the escaped frame transmitter.
// Holds widths, register indexes, reset values and the job types shared by the front end, queue and back end.
`default_nettype none

package eft_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] START_RESET  = 8'h6f;
    localparam logic [BYTE_W-1:0] STOP_RESET   = 8'h65;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h64;

    localparam logic OP_HEADER  = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START,
        CFG_STOP,
        CFG_ESCAPE
    } t_cfg_index;

    typedef enum logic [1:0] {
        JOB_HEADER,
        JOB_PAYLOAD,
        JOB_ERROR
    } t_job_kind;

    typedef enum logic [2:0] {
        SL_IDLE,
        SL_START,
        SL_ID,
        SL_LEN_LO,
        SL_LEN_HI,
        SL_DATA,
        SL_STOP,
        SL_ERR
    } t_slot;

    typedef struct packed {
        t_job_kind         kind;
        logic [BYTE_W-1:0] id;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] data;
        logic              close;
    } t_job;

    typedef struct packed {
        logic push;
        t_job job;
    } t_q_push;

    typedef struct packed {
        logic [BYTE_W-1:0] start;
        logic [BYTE_W-1:0] stop;
        logic [BYTE_W-1:0] escape;
    } t_cfg;

endpackage

`default_nettype wire

// ----- hw/rtl/eft_in_if.sv -----
// Input item channel of the escaped frame transmitter.
// Depends on eft_pkg for field widths.
`default_nettype none

interface eft_in_if import eft_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [BYTE_W-1:0] message_id;
    logic [LEN_W-1:0]  payload_length;
    logic [BYTE_W-1:0] payload_byte;

    modport source (
        output valid, operation, message_id, payload_length, payload_byte,
        input  ready
    );
    modport sink (
        input  valid, operation, message_id, payload_length, payload_byte,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/eft_out_if.sv -----
// Result item channel of the escaped frame transmitter.
// Depends on eft_pkg for field widths.
`default_nettype none

interface eft_out_if import eft_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] line_byte;
    logic              run_last;
    logic              frame_end;
    logic              sequence_error;

    modport source (
        output valid, line_byte, run_last, frame_end, sequence_error,
        input  ready
    );
    modport sink (
        input  valid, line_byte, run_last, frame_end, sequence_error,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/eft_front.sv -----
// Front end: accepts items, tracks the open frame and classifies each item into a job.
// Depends on eft_pkg and eft_in_if.
`default_nettype none

module eft_front import eft_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_full,
    eft_in_if.sink  i_item,
    output t_q_push o_q_push
);

    logic             r_open;
    logic [LEN_W-1:0] r_remaining;
    logic             n_open;
    logic [LEN_W-1:0] n_remaining;
    logic             accept;
    t_job             job;

    assign i_item.ready = !i_q_full;
    assign accept       = i_item.valid && !i_q_full;

    always_comb begin
        n_open      = r_open;
        n_remaining = r_remaining;
        job.kind    = JOB_ERROR;
        job.id      = i_item.message_id;
        job.len     = i_item.payload_length;
        job.data    = i_item.payload_byte;
        job.close   = 1'b0;
        if (i_item.operation == OP_HEADER) begin
            if (!r_open) begin
                job.kind  = JOB_HEADER;
                job.close = (i_item.payload_length == '0);
                if (i_item.payload_length != '0) begin
                    n_open      = 1'b1;
                    n_remaining = i_item.payload_length;
                end
            end
        end else begin
            if (r_open && r_remaining != '0) begin
                job.kind    = JOB_PAYLOAD;
                job.close   = (r_remaining == LEN_W'(1));
                n_remaining = r_remaining - LEN_W'(1);
                if (r_remaining == LEN_W'(1)) begin
                    n_open = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_remaining <= '0;
        end else if (accept) begin
            r_open      <= n_open;
            r_remaining <= n_remaining;
        end
    end

    assign o_q_push.push = accept;
    assign o_q_push.job  = job;

endmodule

`default_nettype wire

// ----- hw/rtl/eft_queue.sv -----
// Job queue between the front end and the byte sequencer.
// Depends on eft_pkg for the job type.
`default_nettype none

module eft_queue import eft_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_push i_q_push,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_empty,
    output t_job    o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_q_push.push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_q_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/eft_back.sv -----
// Back end: walks each job byte by byte, inserts escapes and drives the result register.
// Depends on eft_pkg and eft_out_if.
`default_nettype none

module eft_back import eft_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_q_empty,
    input  t_job      i_head,
    output logic      o_pop,
    eft_out_if.source o_result
);

    t_slot             r_slot;
    t_slot             n_slot;
    logic              r_esc_sent;
    logic              n_esc_sent;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;
    logic              r_out_end;
    logic              r_out_err;

    t_slot             cur_slot;
    t_slot             next_slot;
    logic              can_load;
    logic              go;
    logic              is_data;
    logic              reserved;
    logic              esc_phase;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_last;

    function automatic t_slot first_slot(input t_job_kind kind);
        case (kind)
            JOB_HEADER:  return SL_START;
            JOB_PAYLOAD: return SL_DATA;
            default:     return SL_ERR;
        endcase
    endfunction

    function automatic t_slot after(input t_slot slot, input logic close);
        case (slot)
            SL_START:  return SL_ID;
            SL_ID:     return SL_LEN_LO;
            SL_LEN_LO: return SL_LEN_HI;
            SL_LEN_HI: return close ? SL_STOP : SL_IDLE;
            SL_DATA:   return close ? SL_STOP : SL_IDLE;
            default:   return SL_IDLE;
        endcase
    endfunction

    assign can_load = !r_out_valid || o_result.ready;
    assign go       = !i_q_empty && can_load;
    assign cur_slot = (r_slot == SL_IDLE) ? first_slot(i_head.kind) : r_slot;

    always_comb begin
        case (cur_slot)
            SL_ID:     data_byte = i_head.id;
            SL_LEN_LO: data_byte = i_head.len[BYTE_W-1:0];
            SL_LEN_HI: data_byte = i_head.len[LEN_W-1:BYTE_W];
            SL_DATA:   data_byte = i_head.data;
            default:   data_byte = '0;
        endcase
    end

    assign is_data   = (cur_slot == SL_ID) || (cur_slot == SL_LEN_LO)
                    || (cur_slot == SL_LEN_HI) || (cur_slot == SL_DATA);
    assign reserved  = (data_byte == i_cfg.start) || (data_byte == i_cfg.stop)
                    || (data_byte == i_cfg.escape);
    assign esc_phase = is_data && reserved && !r_esc_sent;
    assign next_slot = after(cur_slot, i_head.close);

    always_comb begin
        n_slot     = r_slot;
        n_esc_sent = r_esc_sent;
        emit_last  = 1'b0;
        case (cur_slot)
            SL_START: emit_byte = i_cfg.start;
            SL_STOP:  emit_byte = i_cfg.stop;
            SL_ERR:   emit_byte = '0;
            default:  emit_byte = data_byte;
        endcase
        if (esc_phase) begin
            emit_byte  = i_cfg.escape;
            n_esc_sent = 1'b1;
            n_slot     = cur_slot;
        end else begin
            n_esc_sent = 1'b0;
            n_slot     = next_slot;
            emit_last  = (next_slot == SL_IDLE);
        end
    end

    assign o_pop = go && emit_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= SL_IDLE;
            r_esc_sent  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (go) begin
                r_slot     <= n_slot;
                r_esc_sent <= n_esc_sent;
            end
            if (can_load) begin
                r_out_valid <= go;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out_byte <= emit_byte;
            r_out_last <= emit_last;
            r_out_end  <= (cur_slot == SL_STOP);
            r_out_err  <= (cur_slot == SL_ERR);
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.line_byte      = r_out_byte;
    assign o_result.run_last       = r_out_last;
    assign o_result.frame_end      = r_out_end;
    assign o_result.sequence_error = r_out_err;

endmodule

`default_nettype wire

// ----- hw/rtl/escaped_frame_transmitter.sv -----
// Escaped frame transmitter top level: configuration registers, front end, job queue, back end.
// Depends on eft_pkg, eft_in_if, eft_out_if, eft_front, eft_queue and eft_back.
//
// Usage:
//   i_item carries header items (operation 0: message id, payload length) and
//   payload items (operation 1: one byte). o_result carries the line bytes in
//   sending order; run_last marks the last byte caused by an input item.
//   Start, stop and escape values are written on i_cfg_we/i_cfg_index/i_cfg_data;
//   the user must write them only while the block is idle; the block does not enforce
//   this. Indexes beyond the escape register are ignored. An accepted item goes into
//   the job queue, then the back end walks it into the result register. The back end
//   sends one line byte per cycle while the receiver is ready. Line bytes per item:
//   4 to 8 for a header, 1 to 3 for a payload byte, 1 for an out-of-order item. The
//   front end takes one item per cycle while the job queue (QUEUE_DEPTH jobs) has room.
//   Reset clears the open frame, the queue and the result register, and loads
//   the default start, stop and escape values.
//   When the receiver stalls, the result register holds, the back end waits,
//   and items keep entering until the queue fills, then i_item.ready drops.
`default_nettype none

module escaped_frame_transmitter import eft_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    eft_in_if.sink               i_item,
    eft_out_if.source            o_result
);

    t_cfg    r_cfg;
    t_q_push q_push;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;
    t_job    q_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start  <= START_RESET;
            r_cfg.stop   <= STOP_RESET;
            r_cfg.escape <= ESCAPE_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_START:  r_cfg.start  <= i_cfg_data;
                CFG_STOP:   r_cfg.stop   <= i_cfg_data;
                CFG_ESCAPE: r_cfg.escape <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    eft_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_full (q_full),
        .i_item   (i_item),
        .o_q_push (q_push)
    );

    eft_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_push (q_push),
        .i_pop    (q_pop),
        .o_full   (q_full),
        .o_empty  (q_empty),
        .o_head   (q_head)
    );

    eft_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_head    (q_head),
        .o_pop     (q_pop),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/eft_checker.sv -----
// Port-level checks on the result channel of the escaped frame transmitter.
// Depends on eft_pkg; bound to escaped_frame_transmitter below.
`default_nettype none

module eft_checker import eft_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              i_ready,
    input logic [BYTE_W-1:0] i_line_byte,
    input logic              i_run_last,
    input logic              i_frame_end,
    input logic              i_sequence_error
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid right after reset");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_sequence_error |->
            i_run_last && !i_frame_end && i_line_byte == '0)
        else $error("error item malformed");

    a_stop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_frame_end |->
            i_run_last && !i_sequence_error)
        else $error("stop byte not last of its item");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=>
            i_valid && $stable(i_line_byte) && $stable(i_run_last))
        else $error("stalled item changed");

endmodule

bind escaped_frame_transmitter eft_checker u_eft_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_result.valid),
    .i_ready          (o_result.ready),
    .i_line_byte      (o_result.line_byte),
    .i_run_last       (o_result.run_last),
    .i_frame_end      (o_result.frame_end),
    .i_sequence_error (o_result.sequence_error)
);

`default_nettype wire
